// ===== rtl/assert_macros.svh =====
// Assertion macros included by the top level, the one RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SHASH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence on the next edge.
`define SHASH_ASSERT_NEXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) else $error(msg);

`endif

// ===== rtl/shash_pkg.sv =====
// Types, constants and helper functions shared by the SHA-256 hasher.
`default_nettype none

package shash_pkg;

	typedef logic [31:0] word_t;
	typedef logic [0:7][31:0] hash_t;     // index 0 is word a / H0

	typedef struct packed {
		word_t w0;     // W[t]
		word_t w1;     // W[t+1]
		word_t w9;     // W[t+9]
		word_t w14;    // W[t+14]
	} taps_t;

	typedef struct packed {
		hash_t v;      // working variables after the round
		word_t w_new;  // W[t+16]
	} rnd_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_ADD,
		ST_OUT
	} state_t;

	localparam logic [5:0] PosLast   = 6'd63;
	localparam logic [5:0] PosLength = 6'd56;
	localparam logic [5:0] RoundLast = 6'd63;
	localparam logic [7:0] PadMark   = 8'h80;
	localparam logic [2:0] WordLast  = 3'd7;

	localparam hash_t InitHash = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		logic [63:0] d;
		d = {x, x} >> n;
		return d[31:0];
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/shash_round.sv =====
// One SHA-256 round together with one step of the message schedule.
`default_nettype none

module shash_round (
	input  shash_pkg::hash_t    v,
	input  shash_pkg::taps_t    taps,
	input  shash_pkg::word_t    k,
	output shash_pkg::rnd_out_t res
);
	import shash_pkg::*;

	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	always_comb begin
		ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
		maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
		t1  = v[7] + big_sigma1(v[4]) + ch + k + taps.w0;
		t2  = big_sigma0(v[0]) + maj;
		res.v = {t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
		// Next schedule word, produced every round so the window simply rolls.
		res.w_new = small_sigma1(taps.w14) + taps.w9 + small_sigma0(taps.w1) + taps.w0;
	end

endmodule

`default_nettype wire

// ===== rtl/sha256_stream_hasher_top.sv =====
// Top level of the byte-serial SHA-256 stream hasher.
// The slave channel takes one request per message byte: tdata carries the byte,
// tuser says whether the byte is part of the message, and tlast closes the
// message. A request with tuser low and tlast high ends the message with no
// further byte, so the empty message can be hashed; with both low it is ignored.
// The 64th byte of a block starts the shared round unit, which runs one round
// per cycle through all 64 rounds and then folds the result into the chaining
// value, with tready low throughout. A closing request starts the padding
// sequencer, which feeds one pad or length byte per cycle (at most 72) except
// while a full pad block is compressed, and reuses the round unit for one or
// two final blocks. The eight digest words then leave on the master channel,
// word first, with the word index beside it and tlast on the eighth word. For
// long messages the single round unit sets the throughput.
// The master side holds its word while tready is low; no new input is taken
// until the last digest word is accepted, after which the chaining value and
// bit count return to their initial values. Reset returns the block to idle
// with the initial hash value and an empty message.
`default_nettype none

module sha256_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,    // [0] byte_present
	input  logic        s_axis_tlast,    // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,    // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_axis_tlast     // last_word
);
	import shash_pkg::*;

	`include "assert_macros.svh"

	state_t      state_q;
	state_t      state_d;
	hash_t       cv_q;
	hash_t       v_q;
	word_t       win_q [16];
	logic [23:0] acc_q;
	logic [63:0] len_q;
	logic [5:0]  pos_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        pad_q;     // closing sequence in progress
	logic        mark_q;    // 0x80 already placed
	logic        wrap_q;    // current pad block has no room for the length
	logic        final_q;   // block under compression is the last one

	logic        in_fire;
	logic        out_fire;
	logic        push_en;
	logic [7:0]  push_byte;
	logic [7:0]  pad_byte;
	logic        blk_full;
	logic        last_blk;
	logic        shift_en;
	word_t       shift_word;
	taps_t       taps;
	rnd_out_t    rnd;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// Pad byte for the current block position: the marker, then zeros, then the
	// bit length most significant byte first in the last eight positions.
	always_comb begin
		pad_byte = '0;
		if (!mark_q) begin
			pad_byte = PadMark;
		end else if (pos_q >= PosLength && !wrap_q) begin
			pad_byte = len_q[{~pos_q[2:0], 3'b000} +: 8];
		end
	end

	assign push_en   = (in_fire && s_axis_tuser[0]) || (state_q == ST_PAD);
	assign push_byte = (state_q == ST_PAD) ? pad_byte : s_axis_tdata;
	assign blk_full  = push_en && (pos_q == PosLast);
	assign last_blk  = (state_q == ST_PAD) && mark_q && !wrap_q;

	assign taps.w0  = win_q[0];
	assign taps.w1  = win_q[1];
	assign taps.w9  = win_q[9];
	assign taps.w14 = win_q[14];

	shash_round u_round (
		.v    (v_q),
		.taps (taps),
		.k    (RoundK[rnd_q]),
		.res  (rnd)
	);

	// The window rolls both when a message word completes and on every round.
	assign shift_en   = (push_en && (pos_q[1:0] == 2'd3)) || (state_q == ST_COMP);
	assign shift_word = (state_q == ST_COMP) ? rnd.w_new : {acc_q, push_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (blk_full) begin
						state_d = ST_COMP;
					end else if (s_axis_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (blk_full) begin
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				if (rnd_q == RoundLast) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (final_q) begin
					state_d = ST_OUT;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_fire && idx_q == WordLast) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state, chaining value and bit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q    <= InitHash;
			len_q   <= '0;
			pos_q   <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			pad_q   <= 1'b0;
			mark_q  <= 1'b0;
			wrap_q  <= 1'b0;
			final_q <= 1'b0;
		end else begin
			if (push_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (in_fire && s_axis_tuser[0]) begin
				len_q <= len_q + 64'd8;
			end
			if (in_fire && s_axis_tlast) begin
				pad_q  <= 1'b1;
				mark_q <= 1'b0;
				wrap_q <= 1'b0;
			end
			if (state_q == ST_PAD) begin
				mark_q <= 1'b1;
				if (!mark_q && pos_q >= PosLength && pos_q != PosLast) begin
					wrap_q <= 1'b1;
				end else if (pos_q == PosLast) begin
					wrap_q <= 1'b0;
				end
			end
			if (blk_full) begin
				rnd_q   <= '0;
				final_q <= last_blk;
			end
			if (state_q == ST_COMP) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 8; i++) begin
					cv_q[i] <= cv_q[i] + v_q[i];
				end
				idx_q <= '0;
			end
			if (out_fire) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == WordLast) begin
					cv_q    <= InitHash;
					len_q   <= '0;
					pad_q   <= 1'b0;
					final_q <= 1'b0;
				end
			end
		end
	end

	// Datapath registers: schedule window, partial word and working variables.
	always_ff @(posedge clk) begin
		if (push_en && pos_q[1:0] != 2'd3) begin
			acc_q <= {acc_q[15:0], push_byte};
		end
		if (shift_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= shift_word;
		end
		if (blk_full) begin
			v_q <= cv_q;
		end else if (state_q == ST_COMP) begin
			v_q <= rnd.v;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {5'b00000, idx_q, cv_q[idx_q]};
	assign m_axis_tlast  = (idx_q == WordLast);

	`SHASH_ASSERT(a_one_side, !(s_axis_tready && m_axis_tvalid), "input and output open together")
	`SHASH_ASSERT_NEXT(a_block_aligned, state_q != ST_COMP && state_d == ST_COMP, pos_q == 6'd0 && rnd_q == 6'd0, "compression started off a block boundary")
	`SHASH_ASSERT_NEXT(a_restart, out_fire && m_axis_tlast, s_axis_tready && len_q == 64'd0 && !pad_q, "hasher did not restart after the digest")
	`SHASH_ASSERT(a_final_in_close, !final_q || pad_q, "final block flagged outside a closing sequence")

endmodule

`default_nettype wire

// ===== test/tb_sha256_stream_hasher_top.sv =====
// Self-checking testbench for the byte-serial SHA-256 stream hasher, with its own digest predictor.
`default_nettype none

package sha256_digest_pkg;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_word_t;

	localparam logic [31:0] FIRST_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_ADD [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_START = 8'h80;
	localparam int LENGTH_SLOT = 56;
	localparam int DIGEST_WORDS = 8;

	function automatic logic [31:0] rot_r(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	class digest_scoreboard;
		logic [31:0] hash_state [8];
		logic [7:0]  msg_block [64];
		logic [63:0] bit_count;
		digest_word_t expected_words [$];
		int unsigned failures;
		int unsigned words_checked;
		int unsigned digests_predicted;

		function new();
			restart();
			for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
			failures = 0;
			words_checked = 0;
			digests_predicted = 0;
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++) hash_state[i] = FIRST_HASH[i];
			bit_count = 64'd0;
		endfunction

		function void compress_block();
			logic [31:0] w [64];
			logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
			for (int t = 0; t < 16; t++)
				w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
			for (int t = 16; t < 64; t++) begin
				s0 = rot_r(w[t-15], 7) ^ rot_r(w[t-15], 18) ^ (w[t-15] >> 3);
				s1 = rot_r(w[t-2], 17) ^ rot_r(w[t-2], 19) ^ (w[t-2] >> 10);
				w[t] = s1 + w[t-7] + s0 + w[t-16];
			end
			a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
			e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
			for (int r = 0; r < 64; r++) begin
				t1 = h + (rot_r(e, 6) ^ rot_r(e, 11) ^ rot_r(e, 25)) + ((e & f) ^ (~e & g))
					+ ROUND_ADD[r] + w[r];
				t2 = (rot_r(a, 2) ^ rot_r(a, 13) ^ rot_r(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				h = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
			hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
		endfunction

		// Called for every accepted request; a closing request queues eight digest words.
		function void note_request(input logic [7:0] data, input logic present, input logic closing);
			int pos;
			logic [63:0] len;
			digest_word_t dw;
			if (present) begin
				pos = int'(bit_count[8:3]);
				msg_block[pos] = data;
				bit_count += 64'd8;
				if (pos == 63) compress_block();
			end
			if (!closing) return;
			len = bit_count;
			pos = int'(len[8:3]);
			msg_block[pos] = PAD_START;
			for (int j = pos + 1; j < 64; j++) msg_block[j] = 8'h00;
			// No room left for the length field: finish this block and pad a fresh one.
			if (pos >= LENGTH_SLOT) begin
				compress_block();
				for (int j = 0; j < 64; j++) msg_block[j] = 8'h00;
			end
			for (int j = 0; j < 8; j++) msg_block[LENGTH_SLOT + j] = len[8*(7-j) +: 8];
			compress_block();
			for (int j = 0; j < DIGEST_WORDS; j++) begin
				dw.word = hash_state[j];
				dw.index = 3'(j);
				dw.last = (j == DIGEST_WORDS - 1);
				expected_words.push_back(dw);
			end
			digests_predicted++;
			restart();
		endfunction

		function void check_word(input logic [31:0] word, input logic [2:0] index, input logic last);
			digest_word_t dw;
			if (expected_words.size() == 0) begin
				$error("unexpected digest word %08h (index %0d), none was due", word, index);
				failures++;
				return;
			end
			dw = expected_words.pop_front();
			words_checked++;
			if (word !== dw.word) begin
				$error("digest_word mismatch: expected %08h, got %08h", dw.word, word);
				failures++;
			end
			if (index !== dw.index) begin
				$error("word_index mismatch: expected %0d, got %0d", dw.index, index);
				failures++;
			end
			if (last !== dw.last) begin
				$error("last_word mismatch: expected %0b, got %0b", dw.last, last);
				failures++;
			end
		endfunction

		function int unsigned words_due();
			return expected_words.size();
		endfunction
	endclass

endpackage

module tb_sha256_stream_hasher_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sha256_digest_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;    // [7:0] data_byte
	logic [0:0]  s_axis_tuser;    // [0] byte_present
	logic        s_axis_tlast;    // end_of_message
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;    // [31:0] digest_word, [34:32] word_index, rest zero
	logic        m_axis_tlast;    // last_word

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	// Byte and closing requests sent; idle requests are not counted.
	int unsigned message_requests;

	digest_scoreboard sb;

	sha256_stream_hasher_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The receiver drops tready at random according to the current phase.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Every digest word taken by the receiver is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
	end

	// Offers one request and returns at the edge that accepts it. tvalid stays high
	// afterwards so that back-to-back requests never lower and raise it in one step;
	// it is only dropped when the sender decides to idle.
	task automatic send_request(input logic [7:0] data, input logic present, input logic closing);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_axis_tvalid   <= 1'b1;
		s_axis_tdata    <= data;
		s_axis_tuser[0] <= present;
		s_axis_tlast    <= closing;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(data, present, closing);
		if (present || closing) message_requests++;
	endtask

	// Sends a message of random bytes with idle requests mixed in. The message is closed
	// either on its last byte or by a separate empty closing request; an empty message
	// always takes the second form.
	task automatic send_message(input int unsigned len);
		bit empty_close;
		empty_close = (len == 0) || ($urandom_range(0, 2) == 0);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
			send_request(8'($urandom), 1'b1, !empty_close && (i == len - 1));
		end
		if (empty_close) send_request(8'($urandom), 1'b0, 1'b1);
	endtask

	// One idling phase: short messages until four or more requests are sent, then
	// one message whose length the caller picks to land on a block or padding boundary.
	task automatic run_phase(input int unsigned sender_pct, input int unsigned receiver_pct,
			input int unsigned long_len);
		int unsigned start_count;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		start_count = message_requests;
		while (message_requests - start_count < 4) send_message($urandom_range(0, 9));
		send_message(long_len);
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		message_requests = 0;
		arst_n          <= 1'b0;
		s_axis_tvalid   <= 1'b0;
		s_axis_tdata    <= 8'h00;
		s_axis_tuser    <= 1'b0;
		s_axis_tlast    <= 1'b0;
		m_axis_tready   <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The empty message, with a nonzero byte that must be ignored.
		send_request(8'ha5, 1'b0, 1'b1);
		// An idle request with all data bits set, then "abc" closed on its last byte.
		send_request(8'hff, 1'b0, 1'b0);
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		// A single zero byte closed on the byte itself.
		send_request(8'h00, 1'b1, 1'b1);
		// All-ones byte, an idle request, the pad marker as data, then an empty close.
		send_request(8'hff, 1'b1, 1'b0);
		send_request(8'h3c, 1'b0, 1'b0);
		send_request(8'h80, 1'b1, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
		// Three more bytes, 7f, 01 and fe, closed on the last byte.
		send_request(8'h7f, 1'b1, 1'b0);
		send_request(8'h01, 1'b1, 1'b0);
		send_request(8'hfe, 1'b1, 1'b1);

		// Random part. The first two phases end on a padding case each: a length field
		// that needs a second block, then a full block followed by a pad-only block.
		// The last phase runs short messages with no idling on either side.
		run_phase(29, 80, 56);
		run_phase(80, 29, 64);
		run_phase(0, 0, $urandom_range(0, 9));
		s_axis_tvalid <= 1'b0;

		// Drain the outstanding digests, then give the block time for anything stray.
		while (sb.words_due() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Hashed %0d messages from %0d byte and closing requests; %0d digest words checked.",
			sb.digests_predicted, message_requests, sb.words_checked);
		$display("Covered the empty message, closing with and without a byte, idle requests,",
			" and padding that spills into a second block.");
		if (sb.failures == 0 && sb.words_due() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run, even with heavy stalls on both sides.
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
